// ----- rtl/core/sli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared widths, codes and control types for the sorted list insert engine.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 6;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_SORTED = 2'd1,
      REQ_READ   = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell of the row
   typedef struct packed {
      logic insert;   // place new value, shift later entries up
      logic sorted;   // placement by compare, else at the tail
      logic rotate;   // move valid entries one toward the head, head wraps to tail
   } cell_ctl_type;

endpackage : sli_pkg
`default_nettype wire

// ----- rtl/core/sli_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_req_if / sli_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface sli_req_if import sli_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [REQ_TYPE_W-1:0]       req_type;
   logic signed [VALUE_W-1:0]   value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface : sli_req_if

interface sli_rsp_if import sli_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic [POS_W-1:0]            position;
   logic signed [VALUE_W-1:0]   entry_value;
   logic [COUNT_W-1:0]          count;
   logic                        last;

   modport source (output valid, output status, output position, output entry_value,
                   output count, output last, input ready);
   modport sink   (input valid, input status, input position, input entry_value,
                   input count, input last, output ready);
endinterface : sli_rsp_if
`default_nettype wire

// ----- rtl/core/sli_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_cell
// One storage slot of the row: compares, shifts up on insert, rotates on read.
// ----------------------------------------------------------------------------
module sli_cell import sli_pkg::*; (
   input  wire logic                      clock,
   input  wire cell_ctl_type              ctl,
   input  wire logic signed [VALUE_W-1:0] new_value,
   input  wire logic signed [VALUE_W-1:0] prev_value,
   input  wire logic signed [VALUE_W-1:0] next_value,
   input  wire logic signed [VALUE_W-1:0] head_value,
   input  wire logic                      found_in,
   input  wire logic                      is_valid,
   input  wire logic                      at_slot,
   input  wire logic                      is_tail,
   output      logic signed [VALUE_W-1:0] value,
   output      logic                      found_out,
   output      logic                      place
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      hit;

   // first slot that is not less than the new value, or the free tail slot
   assign hit       = at_slot || (ctl.sorted && is_valid && !(value_ff < new_value));
   assign found_out = found_in || hit;
   assign place     = hit && !found_in;

   always_comb begin
      priority if (ctl.insert) begin
         if (found_in) begin
            value_in = prev_value;
         end else if (hit) begin
            value_in = new_value;
         end else begin
            value_in = value_ff;
         end
      end else if (ctl.rotate) begin
         value_in = is_tail ? head_value : next_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule : sli_cell
`default_nettype wire

// ----- rtl/core/sli_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_chain
// Row of cells with the placement-found chain and the slot position encoder.
// ----------------------------------------------------------------------------
module sli_chain import sli_pkg::*; #(
   parameter int CAPACITY = 32,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  wire logic                      clock,
   input  wire cell_ctl_type              ctl,
   input  wire logic signed [VALUE_W-1:0] new_value,
   input  wire logic [CNT_W-1:0]          count,
   output      logic signed [VALUE_W-1:0] head_value,
   output      logic [IDX_W-1:0]          place_pos
);

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY:0]         found;
   logic [CAPACITY-1:0]       place;

   assign found[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_value = cell_value[i];
      end else begin : g_body
         assign prev_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      sli_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_value  (new_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .head_value (cell_value[0]),
         .found_in   (found[i]),
         .is_valid   (CNT_W'(i) < count),
         .at_slot    (CNT_W'(i) == count),
         .is_tail    (CNT_W'(i + 1) == count),
         .value      (cell_value[i]),
         .found_out  (found[i+1]),
         .place      (place[i])
      );
   end

   assign head_value = cell_value[0];

   // place is one-hot whenever the row is not full
   always_comb begin
      place_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (place[i]) begin
            place_pos = place_pos | IDX_W'(i);
         end
      end
   end

endmodule : sli_chain
`default_nettype wire

// ----- rtl/core/sorted_list_insert_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_engine
// Ordered list of signed words held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel   role   words
//  req_ch    sink   req_type, value (append / sorted insert / read all)
//  rsp_ch    source status, position, entry_value, count, last
//
//  Append and sorted insert: every cell compares against the new word in
//  parallel and the row shifts up in place; one ack word follows.
//  Read: the valid cells rotate toward the head, one word out per cycle while
//  rsp_ch is not stalled, and the list is back in order after the last word.
//  A single output register carries results; a stalled rsp_ch stalls req_ch.
//  Reset (synchronous) empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_insert_engine import sli_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   sli_req_if.sink   req_ch,
   sli_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [IDX_W-1:0]          read_idx_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [POS_W-1:0]          rsp_position_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_last_ff;

   logic                      out_free;
   logic                      req_fire;
   logic                      is_write;
   logic                      is_full;
   logic                      read_last;
   logic                      rsp_load;
   cell_ctl_type              ctl;
   logic signed [VALUE_W-1:0] head_value;
   logic [IDX_W-1:0]          place_pos;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_write     = (req_ch.req_type == REQ_APPEND) || (req_ch.req_type == REQ_SORTED);
   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign read_last    = ((CNT_W'(read_idx_ff) + CNT_W'(1)) == count_ff);

   // output register takes a new word this cycle
   assign rsp_load = (state_ff == ST_IDLE) ?
                     (req_fire && (is_write ||
                                   ((req_ch.req_type == REQ_READ) && (count_ff == '0)))) :
                     out_free;

   assign ctl.insert = req_fire && is_write && !is_full;
   assign ctl.sorted = (req_ch.req_type == REQ_SORTED);
   assign ctl.rotate = (state_ff == ST_READ) && out_free;

   sli_chain #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .new_value  (req_ch.value),
      .count      (count_ff),
      .head_value (head_value),
      .place_pos  (place_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         read_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ch.ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  priority if (is_write) begin
                     rsp_value_ff  <= '0;
                     rsp_last_ff   <= 1'b1;
                     if (is_full) begin
                        rsp_status_ff   <= STAT_FULL;
                        rsp_position_ff <= POS_W'(count_ff);
                        rsp_count_ff    <= COUNT_W'(count_ff);
                     end else begin
                        count_ff        <= count_ff + CNT_W'(1);
                        rsp_status_ff   <= STAT_OK;
                        rsp_position_ff <= POS_W'(place_pos);
                        rsp_count_ff    <= COUNT_W'(count_ff + CNT_W'(1));
                     end
                  end else if (req_ch.req_type == REQ_READ) begin
                     if (count_ff == '0) begin
                        rsp_status_ff   <= STAT_EMPTY;
                        rsp_position_ff <= '0;
                        rsp_value_ff    <= '0;
                        rsp_count_ff    <= '0;
                        rsp_last_ff     <= 1'b1;
                     end else begin
                        state_ff    <= ST_READ;
                        read_idx_ff <= '0;
                     end
                  end else begin
                     // unused code: dropped, no response
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               if (out_free) begin
                  rsp_status_ff   <= STAT_OK;
                  rsp_position_ff <= POS_W'(read_idx_ff);
                  rsp_value_ff    <= head_value;
                  rsp_count_ff    <= COUNT_W'(count_ff);
                  rsp_last_ff     <= read_last;
                  read_idx_ff     <= read_idx_ff + IDX_W'(1);
                  if (read_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.position    = rsp_position_ff;
   assign rsp_ch.entry_value = rsp_value_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count above capacity");

   a_read_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !req_ch.ready)
      else $error("request taken during read-out");

   a_read_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CNT_W'(read_idx_ff) < count_ff))
      else $error("read index past list end");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

endmodule : sorted_list_insert_engine
`default_nettype wire

// ----- tb/sv/sli_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_list_checker
// Watches the request and response channels of the sorted list insert
// engine, keeps its own copy of the list, works out the response words each
// accepted request must produce and compares them in order as they come out.
// ----------------------------------------------------------------------------
module sli_list_checker import sli_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic clock,
   input  logic reset,
   sli_req_if   req_mon,
   sli_rsp_if   rsp_mon,
   output int   mismatches,
   output int   words_due
);

   typedef struct packed {
      status_type                status;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } rsp_word_type;

   logic signed [VALUE_W-1:0] stored [CAPACITY];
   int                        fill;
   rsp_word_type              due_q [$];

   initial begin
      mismatches = 0;
      words_due  = 0;
      fill       = 0;
   end

   function automatic rsp_word_type make_word(input status_type st, input int pos,
                                              input logic signed [VALUE_W-1:0] v,
                                              input int cnt, input logic fin);
      rsp_word_type w;
      w.status      = st;
      w.position    = POS_W'(pos);
      w.entry_value = v;
      w.count       = COUNT_W'(cnt);
      w.last        = fin;
      return w;
   endfunction

   // updates the list copy and queues the response words of one request
   task automatic apply_request(input logic [REQ_TYPE_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] v);
      int slot;
      bit placed;
      if (kind == REQ_APPEND || kind == REQ_SORTED) begin
         if (fill >= CAPACITY) begin
            due_q.push_back(make_word(STAT_FULL, fill, '0, fill, 1'b1));
         end else begin
            slot   = fill;
            placed = 1'b0;
            // sorted insert goes before the first entry not less than the word
            if (kind == REQ_SORTED) begin
               for (int i = 0; i < fill; i++) begin
                  if (!placed && stored[i] >= v) begin
                     slot   = i;
                     placed = 1'b1;
                  end
               end
            end
            for (int i = fill; i > slot; i--) stored[i] = stored[i-1];
            stored[slot] = v;
            fill++;
            due_q.push_back(make_word(STAT_OK, slot, '0, fill, 1'b1));
         end
      end else if (kind == REQ_READ) begin
         if (fill == 0) begin
            due_q.push_back(make_word(STAT_EMPTY, 0, '0, 0, 1'b1));
         end else begin
            for (int i = 0; i < fill; i++)
               due_q.push_back(make_word(STAT_OK, i, stored[i], fill, i == fill - 1));
         end
      end
      // unused request code: no words, list unchanged
   endtask

   task automatic flag_word(input bit had_expect, input rsp_word_type want);
      mismatches++;
      if (mismatches <= 10) begin
         if (had_expect)
            $display("%0t rsp mismatch: want status %0d pos %0d value %0d count %0d last %0d,",
                     $realtime, want.status, want.position, want.entry_value, want.count,
                     want.last,
                     " got status %0d pos %0d value %0d count %0d last %0d",
                     rsp_mon.status, rsp_mon.position, rsp_mon.entry_value,
                     rsp_mon.count, rsp_mon.last);
         else
            $display("%0t unexpected rsp word: status %0d pos %0d value %0d",
                     $realtime, rsp_mon.status, rsp_mon.position, rsp_mon.entry_value,
                     " count %0d last %0d", rsp_mon.count, rsp_mon.last);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         fill = 0;
         due_q.delete();
      end else begin
         // a word accepted now cannot stem from a request accepted at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               flag_word(1'b0, '0);
            end else begin
               want = due_q.pop_front();
               if (rsp_mon.status !== want.status || rsp_mon.position !== want.position ||
                   rsp_mon.entry_value !== want.entry_value ||
                   rsp_mon.count !== want.count || rsp_mon.last !== want.last)
                  flag_word(1'b1, want);
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.req_type, req_mon.value);
      end
      words_due = due_q.size();
   end

endmodule : sli_list_checker

// ----- tb/sv/tb_sorted_list_insert_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_engine
// Drives append, sorted insert, read and unused requests into the engine,
// first a directed run over the corner cases, then random phases with
// changing idle rates on both sides and one long response stall. Checking is
// done by sli_list_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_engine;
   import sli_pkg::*;

   localparam int CAPACITY        = 32;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int HOLD_CYCLES     = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 40;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   mismatches;
   int   words_due;
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   bit   rsp_hold      = 1'b0;
   int   quiet_cycles  = 0;

   sli_req_if req_ch ();
   sli_rsp_if rsp_ch ();

   sorted_list_insert_engine #(.CAPACITY(CAPACITY)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sli_list_checker #(.CAPACITY(CAPACITY)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random back-pressure, one long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic [REQ_TYPE_W-1:0] kind,
                            input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.value    <= v;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   // stop offering and wait until every queued response word has come out
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
   endtask

   // small values make equal keys common, extremes hit the sign boundary
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return int'($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int sent;
      int roll;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_APPEND;
      req_ch.value    = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty read, equal keys, extremes, unsorted tail, unused code
      send_word(REQ_READ,   0);
      send_word(REQ_SORTED, 0);
      send_word(REQ_SORTED, 0);
      send_word(REQ_APPEND, 32'sh8000_0000);
      send_word(REQ_SORTED, 32'sh7FFF_FFFF);
      send_word(REQ_SORTED, 32'sh8000_0000);
      send_word(REQ_APPEND, 32'sh7FFF_FFFF);
      send_word(REQ_SORTED, -1);
      send_word(REQ_UNUSED, -1);
      send_word(REQ_READ,   -1);
      send_word(REQ_SORTED, 1);
      send_word(REQ_APPEND, 32'sh5555_5555);
      send_word(REQ_SORTED, 32'shAAAA_AAAA);
      send_word(REQ_READ,   0);
      drain();

      // random phases; the list fills up early in the run, later inserts drop
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               rsp_idle_pct  = 79;
            end
            1: begin
               send_idle_pct = 79;
               rsp_idle_pct  = 33;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               rsp_hold      = 1'b1;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               send_word(REQ_UNUSED, pick_value());
            end else begin
               sent++;
               if (roll < 40)
                  send_word(REQ_READ, pick_value());
               else if (roll < 78)
                  send_word(REQ_SORTED, pick_value());
               else
                  send_word(REQ_APPEND, pick_value());
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule : tb_sorted_list_insert_engine
